// ===== hdl/kvtm_pkg.sv =====
// Shared types and constants for the tolerant-match key/value table.
package kvtm_pkg;

	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int TOL_W   = 16;
	localparam int COUNT_W = 5;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register index, taken from the word address bit of paddr.
	localparam logic REG_MATCH_TOLERANCE = 1'b0;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

	typedef enum logic {
		CMD_SET    = 1'b0,
		CMD_LOOKUP = 1'b1
	} command_t;

	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_INSERTED = 3'd1,
		ST_FULL     = 3'd2,
		ST_HIT      = 3'd3,
		ST_MISS     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic                    command;
		logic signed [KEY_W-1:0] key;
		logic [VAL_W-1:0]        value;
	} item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [VAL_W-1:0]   found_value;
		logic [COUNT_W-1:0] entry_count;
	} result_t;

endpackage

// ===== hdl/kvtm_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module kvtm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== hdl/kvtm_cfg.sv =====
// APB-style configuration register block holding the match tolerance.
module kvtm_cfg import kvtm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [TOL_W-1:0]   tolerance
);

	logic [TOL_W-1:0] tol_q;
	logic             sel_tol;

	// Byte lanes are ignored; the word address picks the register.
	assign sel_tol = (paddr[2] == REG_MATCH_TOLERANCE);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (psel && penable && pwrite && sel_tol) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	assign prdata    = sel_tol ? {{(PDATA_W-TOL_W){1'b0}}, tol_q} : '0;
	assign tolerance = tol_q;

endmodule

// ===== hdl/key_value_table_tolerant_match_core.sv =====
// Top level of the tolerant-match key/value table: sequencer, scan compare and stores.
//
// Usage: a transaction is offered on item with start; it is taken at a rising edge
// where start is high and busy is low. A set (command 0) updates the first entry
// whose key lies strictly within the tolerance of the incoming key, or else appends
// a new entry while there is room, or else reports the table full. A lookup
// (command 1) reports a hit with the stored value, or a miss.
// Each transaction produces exactly one result, shown on result for a single cycle
// with done high. The receiver cannot stall, so the result must be taken then.
// Keys and values live in two single-port RAMs that are read together, one entry
// per cycle, from index 0 upward; each registered read is compared while the next
// address goes out. The scan stops at the first match or after the last filled
// entry, and a finishing state then writes the stores and forms the result.
// An empty table skips the scan. A new start may be accepted in the strobe cycle.
// The tolerance register sits at byte address 0 of the configuration port and must
// only be written while the block is idle.
// Reset empties the table (fill count zero), sets the tolerance to 1 (exact
// matching) and clears busy and done; RAM contents need no clearing, as entries at
// or above the fill count are never read.
module key_value_table_tolerant_match_core import kvtm_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  item_t              item,
	output logic               done,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

	state_t state_q, state_d;

	item_t              item_q;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   idx_q;
	logic               cmp_vld_s1;
	logic [CNT_W-1:0]   cmp_idx_s1;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [VAL_W-1:0]   hit_val_q;
	logic               done_q;
	result_t            result_q;

	logic [TOL_W-1:0]   tolerance;
	logic [KEY_W-1:0]   key_rdata;
	logic [VAL_W-1:0]   val_rdata;

	logic               accept;
	logic               issue;
	logic               key_match;
	logic               cmp_last;
	logic signed [KEY_W:0] diff;
	logic [KEY_W:0]     mag;
	logic               is_set;
	logic               room;
	logic               wr_key;
	logic               wr_val;
	logic [IDX_W-1:0]   ram_addr;
	logic [CNT_W-1:0]   fill_d;
	status_t            status_d;

	kvtm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.tolerance (tolerance)
	);

	// Both stores share one address: the scan index while searching, and the
	// target entry in the finishing cycle.
	assign ram_addr = (state_q == S_FINISH) ?
		(hit_q ? hit_idx_q : fill_q[IDX_W-1:0]) : idx_q[IDX_W-1:0];

	kvtm_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (wr_key),
		.re    (issue),
		.addr  (ram_addr),
		.wdata (item_q.key),
		.rdata (key_rdata)
	);

	kvtm_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (wr_val),
		.re    (issue),
		.addr  (ram_addr),
		.wdata (item_q.value),
		.rdata (val_rdata)
	);

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// The difference is taken at 33 bits so that it can never wrap.
	assign diff      = $signed({key_rdata[KEY_W-1], key_rdata}) -
	                   $signed({item_q.key[KEY_W-1], item_q.key});
	assign mag       = diff[KEY_W] ? (KEY_W+1)'(-diff) : diff;
	assign key_match = (mag < {{(KEY_W+1-TOL_W){1'b0}}, tolerance});
	assign cmp_last  = ((cmp_idx_s1 + CNT_W'(1)) == fill_q);

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (fill_q == '0) ? S_FINISH : S_SCAN;
				end
			end
			S_SCAN: begin
				issue = (idx_q < fill_q);
				if (cmp_vld_s1 && (key_match || cmp_last)) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Finishing cycle: store writes, new fill count and result status.
	assign is_set = (item_q.command == CMD_SET);
	assign room   = (fill_q < FULL_COUNT);
	assign wr_key = (state_q == S_FINISH) && is_set && !hit_q && room;
	assign wr_val = (state_q == S_FINISH) && is_set && (hit_q || room);
	assign fill_d = wr_key ? fill_q + CNT_W'(1) : fill_q;

	always_comb begin
		if (is_set) begin
			if (hit_q) begin
				status_d = ST_UPDATED;
			end else if (room) begin
				status_d = ST_INSERTED;
			end else begin
				status_d = ST_FULL;
			end
		end else begin
			status_d = hit_q ? ST_HIT : ST_MISS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			hit_q      <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			cmp_idx_s1 <= idx_q;
			done_q     <= (state_q == S_FINISH);
			if (accept) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if ((state_q == S_SCAN) && cmp_vld_s1 && key_match) begin
				hit_q <= 1'b1;
			end
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if ((state_q == S_SCAN) && cmp_vld_s1 && key_match) begin
			hit_idx_q <= cmp_idx_s1[IDX_W-1:0];
			hit_val_q <= val_rdata;
		end
		if (state_q == S_FINISH) begin
			result_q.status      <= status_d;
			result_q.found_value <= (!is_set && hit_q) ? hit_val_q : '0;
			result_q.entry_count <= COUNT_W'(fill_d);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== hdl/kvtm_checker.sv =====
// Port-level assertions for the tolerant-match key/value table, bound to its top level.
module kvtm_checker import kvtm_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input logic    done,
	input result_t result
);

	// An accepted transaction keeps the block busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an accepted transaction");

	// The end of work and the result strobe coincide.
	a_done_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result strobe");

	// A result never lasts more than one cycle.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// Only a lookup hit carries a non-zero value.
	a_value_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ST_HIT)) |-> (result.found_value == '0))
		else $error("found_value non-zero on a result that is not a hit");

endmodule

bind key_value_table_tolerant_match_core kvtm_checker u_kvtm_checker (.*);
